// File: sv/rlpsd_pkg.sv
// Shared types and constants for the RGB LED panel scan driver.
package rlpsd_pkg;

    localparam int NUM_PLANES = 3;
    localparam int ROW_BITS   = 32;
    localparam int HALF_ROWS  = 8;
    localparam int ADDR_W     = $clog2(HALF_ROWS);

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    localparam int PLANE_RED   = 0;
    localparam int PLANE_GREEN = 1;
    localparam int PLANE_BLUE  = 2;

    localparam int COLOR_RED_BIT   = 2;
    localparam int COLOR_GREEN_BIT = 1;
    localparam int COLOR_BLUE_BIT  = 0;

    localparam logic [2:0] BLOCK_LAST = 3'd7;
    localparam logic [3:0] STEP_LAST  = 4'd15;
    localparam logic [3:0] LATCH_STEP = 4'd13;
    localparam logic [8:0] BLANK_FULL = 9'd256;

    typedef logic [NUM_PLANES-1:0][ROW_BITS-1:0] word_t;

    typedef struct packed {
        logic       func;
        logic [4:0] pixel_x;
        logic [3:0] pixel_y;
        logic [2:0] pixel_color;
    } req_t;

    typedef struct packed {
        logic red_upper;
        logic green_upper;
        logic blue_upper;
        logic red_lower;
        logic green_lower;
        logic blue_lower;
        logic shift_pulse;
        logic row_sel_a;
        logic row_sel_b;
        logic latch;
        logic output_enable;
        logic phase_end;
    } res_t;

endpackage

// File: sv/rlpsd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module rlpsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/rgb_led_panel_scan_driver.sv
// Top level of the RGB LED panel scan driver: scan sequencer and frame store pipeline.
// A tick request gives its pin levels through the read stage and the result register; a pixel write gives none.
// One request is accepted every cycle while not stalled; the frame store read and write-back overlap.
// Requests stall only while a tick holds in the read stage behind a stalled result.
// Reset clears the scan position, brightness and the per-row valid bits, so the
// frame store reads as all black at once, with no clearing pass.
module rgb_led_panel_scan_driver
    import rlpsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  req_t       req_data,
    output logic       res_valid,
    input  logic       res_stall,
    output res_t       res_data,
    input  logic       brightness_we,
    input  logic [7:0] brightness_wdata
);

    logic [7:0]        brightness_reg;
    logic              phase_reg, phase_next;
    logic [2:0]        block_reg, block_next;
    logic [3:0]        step_reg, step_next;
    logic              blank_reg, blank_next;
    logic [8:0]        bcount_reg, bcount_next;

    logic              s1_valid_reg;
    logic              s1_tick_reg;
    logic              s1_half_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [4:0]        s1_col_reg;
    logic [2:0]        s1_color_reg;
    res_t              s1_ctl_reg;

    logic              lw_valid_reg;
    logic              lw_half_reg;
    logic [ADDR_W-1:0] lw_addr_reg;
    word_t             lw_data_reg;

    logic [1:0][HALF_ROWS-1:0] vld_reg;

    logic              res_valid_reg;
    res_t              res_data_reg;

    logic              accept;
    logic              tick;
    logic [4:0]        scan_col;
    logic [ADDR_W-1:0] scan_row;
    logic [8:0]        bcount_inc;
    logic              blank_done;
    res_t              ctl;
    logic [ADDR_W-1:0] rd_addr;
    logic              s1_adv;
    word_t             ram_rdata [2];
    word_t             word_cur [2];
    word_t             wr_word;
    logic              wr_en;
    res_t              res_new;

    assign accept = req_valid && !req_stall;
    assign tick   = (req_data.func == FUNC_TICK);

    // Folded order: the first half of a block runs right to left, the second left to right.
    assign scan_col   = {block_reg[1:0], step_reg[3] ? step_reg[2:0] : ~step_reg[2:0]};
    assign scan_row   = {~block_reg[2], step_reg[3], phase_reg};
    assign bcount_inc = bcount_reg + 9'd1;
    assign blank_done = (bcount_inc >= (BLANK_FULL - {1'b0, brightness_reg}));

    always_comb
    begin
        ctl               = '0;
        ctl.shift_pulse   = !blank_reg;
        ctl.row_sel_a     = phase_reg;
        ctl.row_sel_b     = !phase_reg;
        ctl.latch         = !blank_reg && (block_reg == BLOCK_LAST) && (step_reg >= LATCH_STEP);
        ctl.output_enable = blank_reg;
        ctl.phase_end     = blank_reg && blank_done;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        block_next  = block_reg;
        step_next   = step_reg;
        blank_next  = blank_reg;
        bcount_next = bcount_reg;
        if (accept && tick)
        begin
            priority if (!blank_reg)
            begin
                if (step_reg == STEP_LAST)
                begin
                    step_next = '0;
                    if (block_reg == BLOCK_LAST)
                    begin
                        block_next  = '0;
                        blank_next  = 1'b1;
                        bcount_next = '0;
                    end
                    else
                    begin
                        block_next = block_reg + 3'd1;
                    end
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            else if (blank_done)
            begin
                blank_next  = 1'b0;
                bcount_next = '0;
                phase_next  = !phase_reg;
                block_next  = '0;
                step_next   = '0;
            end
            else
            begin
                bcount_next = bcount_inc;
            end
        end
    end

    assign s1_adv    = s1_valid_reg && (!s1_tick_reg || !res_valid_reg || !res_stall);
    assign req_stall = s1_valid_reg && !s1_adv;

    always_comb
    begin
        priority if (accept && tick)
        begin
            rd_addr = scan_row;
        end
        else if (accept)
        begin
            rd_addr = req_data.pixel_y[ADDR_W-1:0];
        end
        else
        begin
            rd_addr = s1_addr_reg;
        end
    end

    for (genvar h = 0; h < 2; h++)
    begin : g_half
        rlpsd_ram #(
            .WIDTH ($bits(word_t)),
            .DEPTH (HALF_ROWS)
        ) u_ram (
            .clk   (clk),
            .we    (wr_en && (s1_half_reg == 1'(h))),
            .waddr (s1_addr_reg),
            .wdata (wr_word),
            .raddr (rd_addr),
            .rdata (ram_rdata[h])
        );

        // The latest write wins over the RAM, and a row never written reads as black.
        always_comb
        begin
            priority if (lw_valid_reg && (lw_half_reg == 1'(h)) && (lw_addr_reg == s1_addr_reg))
            begin
                word_cur[h] = lw_data_reg;
            end
            else if (vld_reg[h][s1_addr_reg])
            begin
                word_cur[h] = ram_rdata[h];
            end
            else
            begin
                word_cur[h] = '0;
            end
        end
    end

    assign wr_en = s1_valid_reg && !s1_tick_reg;

    always_comb
    begin
        wr_word                        = word_cur[s1_half_reg];
        wr_word[PLANE_RED][s1_col_reg]   = s1_color_reg[COLOR_RED_BIT];
        wr_word[PLANE_GREEN][s1_col_reg] = s1_color_reg[COLOR_GREEN_BIT];
        wr_word[PLANE_BLUE][s1_col_reg]  = s1_color_reg[COLOR_BLUE_BIT];
    end

    always_comb
    begin
        res_new = s1_ctl_reg;
        if (!s1_ctl_reg.output_enable)
        begin
            res_new.red_upper   = word_cur[0][PLANE_RED][s1_col_reg];
            res_new.green_upper = word_cur[0][PLANE_GREEN][s1_col_reg];
            res_new.blue_upper  = word_cur[0][PLANE_BLUE][s1_col_reg];
            res_new.red_lower   = word_cur[1][PLANE_RED][s1_col_reg];
            res_new.green_lower = word_cur[1][PLANE_GREEN][s1_col_reg];
            res_new.blue_lower  = word_cur[1][PLANE_BLUE][s1_col_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= '0;
            phase_reg      <= 1'b0;
            block_reg      <= '0;
            step_reg       <= '0;
            blank_reg      <= 1'b0;
            bcount_reg     <= '0;
            s1_valid_reg   <= 1'b0;
            lw_valid_reg   <= 1'b0;
            vld_reg        <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (brightness_we)
            begin
                brightness_reg <= brightness_wdata;
            end
            phase_reg  <= phase_next;
            block_reg  <= block_next;
            step_reg   <= step_next;
            blank_reg  <= blank_next;
            bcount_reg <= bcount_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                lw_valid_reg                      <= 1'b1;
                vld_reg[s1_half_reg][s1_addr_reg] <= 1'b1;
            end
            if (s1_adv && s1_tick_reg)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_tick_reg  <= tick;
            s1_ctl_reg   <= ctl;
            s1_color_reg <= req_data.pixel_color;
            if (tick)
            begin
                s1_half_reg <= 1'b0;
                s1_addr_reg <= scan_row;
                s1_col_reg  <= scan_col;
            end
            else
            begin
                s1_half_reg <= req_data.pixel_y[ADDR_W];
                s1_addr_reg <= req_data.pixel_y[ADDR_W-1:0];
                s1_col_reg  <= req_data.pixel_x;
            end
        end
        if (wr_en)
        begin
            lw_half_reg <= s1_half_reg;
            lw_addr_reg <= s1_addr_reg;
            lw_data_reg <= wr_word;
        end
        if (s1_adv && s1_tick_reg)
        begin
            res_data_reg <= res_new;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

// File: sv/rlpsd_checker.sv
// Port-level assertions for the RGB LED panel scan driver and their bind.
module rlpsd_checker
    import rlpsd_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_stall,
    input logic res_valid,
    input logic res_stall,
    input res_t res_data
);

    // A stalled result holds its value.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // Requests are held back only by a full, stalled result register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> res_valid && res_stall)
        else $error("request stall without a stalled result");

    // During blanking the data pins and latch stay low.
    a_blank_dark: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.output_enable |->
            !res_data.red_upper && !res_data.green_upper && !res_data.blue_upper &&
            !res_data.red_lower && !res_data.green_lower && !res_data.blue_lower &&
            !res_data.latch)
        else $error("data or latch active while blanking");

    // A tick either shifts a column or blanks, never both.
    a_shift_xor_blank: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.shift_pulse != res_data.output_enable) &&
            (res_data.row_sel_a != res_data.row_sel_b))
        else $error("inconsistent shift, blank or row select");

    // The end of a phase is always a blank tick.
    a_end_blank: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.phase_end |-> res_data.output_enable)
        else $error("phase end outside blanking");

endmodule

bind rgb_led_panel_scan_driver rlpsd_checker u_rlpsd_checker (.*);

// File: tb/tb_rgb_led_panel_scan_driver.sv
// Self-checking testbench for the RGB LED panel scan driver, with a scan scoreboard class.
module tb_rgb_led_panel_scan_driver;
    import rlpsd_pkg::*;

    localparam int PANEL_ROWS = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int SEGMENT_ITEMS = 105;

    class scan_scoreboard;
        logic [ROW_BITS-1:0] frame_rows [NUM_PLANES*PANEL_ROWS];
        logic scan_phase;
        logic [2:0] block_idx;
        logic [3:0] shift_idx;
        logic blanking;
        logic [8:0] blank_done;
        logic [7:0] brightness;
        res_t expected_q [$];
        int errors;
        int results_seen;
        int writes;
        int ticks;
        int latches;
        int phase_ends;

        function new();
            foreach (frame_rows[i])
            begin
                frame_rows[i] = '0;
            end
            scan_phase = 1'b0;
            block_idx = '0;
            shift_idx = '0;
            blanking = 1'b0;
            blank_done = '0;
            brightness = '0;
            errors = 0;
            results_seen = 0;
            writes = 0;
            ticks = 0;
            latches = 0;
            phase_ends = 0;
        endfunction

        function void set_brightness(logic [7:0] value);
            brightness = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic pixel(int plane, int row, int col);
            return frame_rows[plane*PANEL_ROWS + row][col];
        endfunction

        function void note_request(req_t r);
            res_t want;
            int base_x;
            int base_y;
            int s;
            int col;
            int row;
            logic [8:0] total;
            if (r.func == FUNC_WRITE)
            begin
                frame_rows[PLANE_RED*PANEL_ROWS + r.pixel_y][r.pixel_x] =
                    r.pixel_color[COLOR_RED_BIT];
                frame_rows[PLANE_GREEN*PANEL_ROWS + r.pixel_y][r.pixel_x] =
                    r.pixel_color[COLOR_GREEN_BIT];
                frame_rows[PLANE_BLUE*PANEL_ROWS + r.pixel_y][r.pixel_x] =
                    r.pixel_color[COLOR_BLUE_BIT];
                writes++;
                return;
            end
            ticks++;
            want = '0;
            want.row_sel_a = scan_phase;
            want.row_sel_b = ~scan_phase;
            if (!blanking)
            begin
                base_x = 7 + 8*int'(block_idx[1:0]);
                base_y = (block_idx < 3'd4 ? 4 : 0) + int'(scan_phase);
                s = int'(shift_idx);
                if (s < 8)
                begin
                    col = base_x - s;
                    row = base_y;
                end
                else
                begin
                    col = base_x + s - 15;
                    row = base_y + 2;
                end
                want.red_upper = pixel(PLANE_RED, row, col);
                want.green_upper = pixel(PLANE_GREEN, row, col);
                want.blue_upper = pixel(PLANE_BLUE, row, col);
                want.red_lower = pixel(PLANE_RED, row + HALF_ROWS, col);
                want.green_lower = pixel(PLANE_GREEN, row + HALF_ROWS, col);
                want.blue_lower = pixel(PLANE_BLUE, row + HALF_ROWS, col);
                want.shift_pulse = 1'b1;
                want.latch = (block_idx == BLOCK_LAST) && (shift_idx >= LATCH_STEP);
                if (want.latch)
                begin
                    latches++;
                end
                if (shift_idx == STEP_LAST)
                begin
                    shift_idx = '0;
                    if (block_idx == BLOCK_LAST)
                    begin
                        block_idx = '0;
                        blanking = 1'b1;
                        blank_done = '0;
                    end
                    else
                    begin
                        block_idx = block_idx + 3'd1;
                    end
                end
                else
                begin
                    shift_idx = shift_idx + 4'd1;
                end
            end
            else
            begin
                total = BLANK_FULL - {1'b0, brightness};
                want.output_enable = 1'b1;
                blank_done = blank_done + 9'd1;
                if (blank_done >= total)
                begin
                    want.phase_end = 1'b1;
                    phase_ends++;
                    blanking = 1'b0;
                    blank_done = '0;
                    scan_phase = ~scan_phase;
                    block_idx = '0;
                    shift_idx = '0;
                end
            end
            expected_q.push_back(want);
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10)
            begin
                $display("MISMATCH %s", msg);
            end
        endfunction

        function void compare_bit(string field, logic want, logic got);
            if (got !== want)
            begin
                note_error($sformatf("result %0d %s: expected %b, got %b",
                    results_seen, field, want, got));
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_q.size() == 0)
            begin
                note_error($sformatf("result %b arrived with none expected", got));
                return;
            end
            want = expected_q.pop_front();
            results_seen++;
            compare_bit("red_upper", want.red_upper, got.red_upper);
            compare_bit("green_upper", want.green_upper, got.green_upper);
            compare_bit("blue_upper", want.blue_upper, got.blue_upper);
            compare_bit("red_lower", want.red_lower, got.red_lower);
            compare_bit("green_lower", want.green_lower, got.green_lower);
            compare_bit("blue_lower", want.blue_lower, got.blue_lower);
            compare_bit("shift_pulse", want.shift_pulse, got.shift_pulse);
            compare_bit("row_sel_a", want.row_sel_a, got.row_sel_a);
            compare_bit("row_sel_b", want.row_sel_b, got.row_sel_b);
            compare_bit("latch", want.latch, got.latch);
            compare_bit("output_enable", want.output_enable, got.output_enable);
            compare_bit("phase_end", want.phase_end, got.phase_end);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_data;
    logic res_valid;
    logic res_stall;
    res_t res_data;
    logic brightness_we;
    logic [7:0] brightness_wdata;

    scan_scoreboard sb;
    bit tx_steady;
    bit rx_steady;
    int rx_hold_cycles;
    int brightness_writes;

    rgb_led_panel_scan_driver i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .req_data         (req_data),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .res_data         (res_data),
        .brightness_we    (brightness_we),
        .brightness_wdata (brightness_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic req_t make_request(logic f, int x, int y, int c);
        req_t r;
        r.func = f;
        r.pixel_x = x[4:0];
        r.pixel_y = y[3:0];
        r.pixel_color = c[2:0];
        return r;
    endfunction

    function automatic req_t rand_request(int tick_pct);
        return make_request(($urandom_range(0, 99) < tick_pct) ? FUNC_TICK : FUNC_WRITE,
            $urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 7));
    endfunction

    task automatic send_request(input req_t r);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid = 1'b1;
        req_data = r;
        do @(posedge clk); while (req_stall !== 1'b0);
        sb.note_request(r);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_brightness(input logic [7:0] value);
        wait_drained();
        @(negedge clk);
        brightness_we = 1'b1;
        brightness_wdata = value;
        @(negedge clk);
        brightness_we = 1'b0;
        brightness_wdata = 8'($urandom_range(0, 255));
        sb.set_brightness(value);
        brightness_writes++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
        begin
            sb.check_result(res_data);
        end
    end

    initial
    begin : receiver
        int n;
        res_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
            begin
                n = rx_steady ? 0 : $urandom_range(0, 12);
            end
            if (n > 0)
            begin
                @(negedge clk);
                res_stall = 1'b1;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            res_stall = 1'b0;
            do @(posedge clk); while (res_valid !== 1'b1);
        end
    end

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : main
        logic [7:0] levels [6];
        sb = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        brightness_we = 1'b0;
        brightness_wdata = '0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        rx_hold_cycles = 0;
        brightness_writes = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        program_brightness(8'd255);
        send_request(make_request(FUNC_WRITE, 7, 4, 7));
        send_request(make_request(FUNC_WRITE, 7, 12, 5));
        send_request(make_request(FUNC_WRITE, 6, 4, 2));
        send_request(make_request(FUNC_WRITE, 6, 12, 4));
        send_request(make_request(FUNC_TICK, 0, 0, 0));
        send_request(make_request(FUNC_TICK, 0, 0, 0));
        send_request(make_request(FUNC_WRITE, 0, 0, 7));
        send_request(make_request(FUNC_WRITE, 31, 15, 7));
        send_request(make_request(FUNC_WRITE, 31, 0, 1));
        send_request(make_request(FUNC_WRITE, 0, 15, 6));
        send_request(make_request(FUNC_WRITE, 5, 4, 7));
        send_request(make_request(FUNC_WRITE, 5, 4, 0));
        send_request(make_request(FUNC_WRITE, 4, 12, 3));
        send_request(make_request(FUNC_TICK, 0, 0, 0));
        send_request(make_request(FUNC_TICK, 31, 15, 7));
        send_request(make_request(FUNC_WRITE, 7, 4, 0));
        send_request(make_request(FUNC_TICK, 17, 9, 2));
        send_request(make_request(FUNC_WRITE, 31, 5, 3));
        send_request(make_request(FUNC_TICK, 0, 0, 0));

        // Shorten the blanking time while a phase is already deep in blanking.
        program_brightness(8'd0);
        while (!(sb.blanking && sb.blank_done >= 9'd40))
        begin
            send_request(rand_request(100));
        end
        program_brightness(8'd240);

        levels[0] = 8'd255;
        levels[1] = 8'd0;
        levels[2] = 8'($urandom_range(0, 255));
        levels[3] = 8'd250;
        levels[4] = 8'd128;
        levels[5] = 8'($urandom_range(0, 255));
        for (int seg = 0; seg < 6; seg++)
        begin
            program_brightness(levels[seg]);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            if (seg == 2)
            begin
                rx_hold_cycles = HOLD_CYCLES;
                tx_steady = 1'b1;
                rx_steady = 1'b0;
            end
            for (int k = 0; k < SEGMENT_ITEMS; k++)
            begin
                send_request(rand_request(75));
                if (seg == 2 && k == 60)
                begin
                    tx_steady = 1'b0;
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Run covered %0d pixel writes and %0d scan ticks over %0d brightness settings.",
            sb.writes, sb.ticks, brightness_writes);
        $display("Scan reached %0d latch strobes and %0d phase ends; %0d errors.",
            sb.latches, sb.phase_ends, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// File: sim.f
sv/rlpsd_pkg.sv
sv/rlpsd_ram.sv
sv/rgb_led_panel_scan_driver.sv
sv/rlpsd_checker.sv
tb/tb_rgb_led_panel_scan_driver.sv
